[sv/pcmu_pkg.sv]
package pcmu_pkg;

	localparam int WORD_W  = 64;
	localparam int MASK_W  = 16;
	localparam int LIMIT_W = 31;
	// Wide enough for a lane sum (at most 33 bits) and the limit.
	localparam int CMP_W   = 33;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd15;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	typedef struct packed {
		logic over;
		logic under;
	} lane_flag_t;

endpackage

[sv/pcmu_lane.sv]
module pcmu_lane #(
	parameter int LANE_WIDTH = 4
) (
	input  logic [LANE_WIDTH-1:0]           val,
	input  logic                            step,
	input  logic                            add,
	input  logic [pcmu_pkg::LIMIT_W-1:0]    limit,
	output logic [LANE_WIDTH-1:0]           nw,
	output pcmu_pkg::lane_flag_t            flag
);

	logic [LANE_WIDTH:0]          sum;
	logic [pcmu_pkg::CMP_W-1:0]   sum_ext;

	assign sum     = {1'b0, val} + (LANE_WIDTH+1)'(step);
	assign sum_ext = pcmu_pkg::CMP_W'(sum);

	// Carry out of the lane counts as over limit as well.
	assign flag.over  = add & (sum[LANE_WIDTH] | (sum_ext > pcmu_pkg::CMP_W'(limit)));
	assign flag.under = ~add & step & (val == '0);

	assign nw = add ? sum[LANE_WIDTH-1:0] : (val - LANE_WIDTH'(step));

endmodule

[sv/pcmu_merge.sv]
module pcmu_merge #(
	parameter int LANE_COUNT = 16,
	parameter int LANE_WIDTH = 4
) (
	input  logic [LANE_WIDTH-1:0]          lane_nw   [LANE_COUNT],
	input  pcmu_pkg::lane_flag_t           lane_flag [LANE_COUNT],
	output logic [pcmu_pkg::WORD_W-1:0]    result,
	output pcmu_pkg::status_t              status
);

	localparam int TOT_W = LANE_COUNT * LANE_WIDTH;

	logic [TOT_W-1:0]              lanes_flat;
	logic [LANE_COUNT-1:0]         over_vec;
	logic [LANE_COUNT-1:0]         under_vec;
	logic [pcmu_pkg::WORD_W-1:0]   packed_word;

	for (genvar i = 0; i < LANE_COUNT; i++) begin : g_pack
		assign lanes_flat[i*LANE_WIDTH +: LANE_WIDTH] = lane_nw[i];
		assign over_vec[i]  = lane_flag[i].over;
		assign under_vec[i] = lane_flag[i].under;
	end

	// Drop lane bits that fall above the word, or zero-pad lanes that fall short of it.
	if (TOT_W >= pcmu_pkg::WORD_W) begin : g_trunc
		assign packed_word = lanes_flat[pcmu_pkg::WORD_W-1:0];
	end else begin : g_ext
		assign packed_word = {{(pcmu_pkg::WORD_W-TOT_W){1'b0}}, lanes_flat};
	end

	always_comb begin
		if (|over_vec) begin
			status = pcmu_pkg::ST_OVER;
			result = '0;
		end else if (|under_vec) begin
			status = pcmu_pkg::ST_UNDER;
			result = '0;
		end else begin
			status = pcmu_pkg::ST_OK;
			result = packed_word;
		end
	end

endmodule

[sv/packed_counter_mask_update.sv]
// Pipeline: an accepted input beat is registered in the lane stage, then in the output register, as its result beat.
// Throughput: one beat per cycle while out_ready holds; the lane stage and the output register each hold
// one beat, so input is taken while a finished result waits on the output as long as the lane stage is empty.
// Reset (arst_n low): both stage valids clear at once and lane_limit returns to 15.
module packed_counter_mask_update #(
	parameter int LANE_COUNT = 16,
	parameter int LANE_WIDTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_wr_en,
	input  logic [pcmu_pkg::LIMIT_W-1:0]     cfg_wr_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pcmu_pkg::WORD_W-1:0]      packed_counts,
	input  logic [pcmu_pkg::MASK_W-1:0]      inc_mask,
	input  logic                             req_type,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pcmu_pkg::WORD_W-1:0]      packed_result,
	output logic [1:0]                       status
);

	localparam int TOT_W = LANE_COUNT * LANE_WIDTH;

	// Configuration register: the largest value a counter may hold after an add.
	logic [pcmu_pkg::LIMIT_W-1:0]  lane_limit_q;

	// Lane view of the incoming word, zero-padded when the lanes run past bit 63.
	logic [TOT_W-1:0]              lane_bits;
	logic [LANE_COUNT-1:0]         lane_step;
	logic [LANE_WIDTH-1:0]         lane_nw     [LANE_COUNT];
	pcmu_pkg::lane_flag_t          lane_flag   [LANE_COUNT];

	// Stage 1: per-lane results.
	logic                          valid_s1;
	logic [LANE_WIDTH-1:0]         nw_s1       [LANE_COUNT];
	pcmu_pkg::lane_flag_t          flag_s1     [LANE_COUNT];

	// Stage 2: merged result, held until the consumer takes it.
	logic                          valid_s2;
	logic [pcmu_pkg::WORD_W-1:0]   result_s2;
	pcmu_pkg::status_t             status_s2;

	logic [pcmu_pkg::WORD_W-1:0]   merge_result;
	pcmu_pkg::status_t             merge_status;

	logic                          adv_s1;
	logic                          adv_s2;

	// Each stage moves when the one after it is empty or moving itself.
	assign adv_s2   = ~valid_s2 | out_ready;
	assign adv_s1   = ~valid_s1 | adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_limit_q <= pcmu_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			lane_limit_q <= cfg_wr_data;
		end
	end

	if (TOT_W >= pcmu_pkg::WORD_W) begin : g_pad
		assign lane_bits = TOT_W'(packed_counts);
	end else begin : g_cut
		// Drop word bits above the top lane.
		assign lane_bits = packed_counts[TOT_W-1:0];
	end

	// One core per counter; lanes past the mask width never step.
	for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
		if (i < pcmu_pkg::MASK_W) begin : g_step
			assign lane_step[i] = inc_mask[i];
		end else begin : g_nostep
			assign lane_step[i] = 1'b0;
		end

		pcmu_lane #(
			.LANE_WIDTH (LANE_WIDTH)
		) u_lane (
			.val   (lane_bits[i*LANE_WIDTH +: LANE_WIDTH]),
			.step  (lane_step[i]),
			.add   (req_type),
			.limit (lane_limit_q),
			.nw    (lane_nw[i]),
			.flag  (lane_flag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture lane results on an accepted beat; hold otherwise.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			nw_s1   <= lane_nw;
			flag_s1 <= lane_flag;
		end
	end

	pcmu_merge #(
		.LANE_COUNT (LANE_COUNT),
		.LANE_WIDTH (LANE_WIDTH)
	) u_merge (
		.lane_nw   (nw_s1),
		.lane_flag (flag_s1),
		.result    (merge_result),
		.status    (merge_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= merge_result;
			status_s2 <= merge_status;
		end
	end

	assign out_valid     = valid_s2;
	assign packed_result = result_s2;
	assign status        = status_s2;

endmodule

[test/packed_counter_mask_update_test.sv]
module packed_counter_mask_update_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES       = 16;
	localparam int LANE_BITS   = 4;
	// Slowest sane run: ~1650 beats, each waiting out the longest gap and the
	// longest stall plus the pipeline latency, and the limit pauses. Allow
	// several times that.
	localparam int CYCLE_LIMIT = 400000;

	// Keep the predicted counters and status for every accepted input beat
	// and compare them, oldest first, with the beats leaving the block.
	class counter_scoreboard;
		typedef struct {
			logic [pcmu_pkg::WORD_W-1:0] word;
			pcmu_pkg::status_t           st;
		} update_t;

		logic [pcmu_pkg::LIMIT_W-1:0] limit;
		update_t                      updates_q[$];
		int                           errors;
		int                           n_ok;
		int                           n_over;
		int                           n_under;

		function new();
			limit   = pcmu_pkg::LIMIT_RESET;
			errors  = 0;
			n_ok    = 0;
			n_over  = 0;
			n_under = 0;
		endfunction

		function int pending();
			return updates_q.size();
		endfunction

		// Step every lane, stopping at the first lane that breaks the limit,
		// its own capacity or drops below zero.
		function void note_input(logic [pcmu_pkg::WORD_W-1:0] counts,
				logic [pcmu_pkg::MASK_W-1:0] mask, logic add);
			update_t     u;
			logic [63:0] lm;
			logic [63:0] val;
			logic [63:0] nw;
			logic [63:0] res;
			logic [63:0] bump;
			int          pos;
			int          i;
			lm   = (64'd1 << LANE_BITS) - 64'd1;
			res  = '0;
			u.st = pcmu_pkg::ST_OK;
			for (i = 0; i < LANES; i++) begin
				pos  = i * LANE_BITS;
				val  = '0;
				bump = (i < pcmu_pkg::MASK_W) ? {63'd0, mask[i]} : 64'd0;
				if (pos < pcmu_pkg::WORD_W)
					val = (counts >> pos) & lm;
				if (add) begin
					nw = val + bump;
					if (nw > lm || nw > {33'd0, limit}) begin
						u.st = pcmu_pkg::ST_OVER;
						break;
					end
				end else begin
					if (val < bump) begin
						u.st = pcmu_pkg::ST_UNDER;
						break;
					end
					nw = val - bump;
				end
				if (pos < pcmu_pkg::WORD_W)
					res |= (nw & lm) << pos;
			end
			u.word = (u.st == pcmu_pkg::ST_OK) ? res : '0;
			updates_q.push_back(u);
		endfunction

		function void check_result(logic [pcmu_pkg::WORD_W-1:0] word, logic [1:0] st);
			update_t u;
			if (updates_q.size() == 0) begin
				$display("%0t: result beat with nothing outstanding: word %h status %0d",
					$time, word, st);
				errors++;
				return;
			end
			u = updates_q.pop_front();
			case (u.st)
				pcmu_pkg::ST_OK:    n_ok++;
				pcmu_pkg::ST_OVER:  n_over++;
				default:            n_under++;
			endcase
			if (word !== u.word) begin
				$display("%0t: packed_result expected %h actual %h", $time, u.word, word);
				errors++;
			end
			if (st !== u.st) begin
				$display("%0t: status expected %0d actual %0d", $time, u.st, st);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [pcmu_pkg::LIMIT_W-1:0]  cfg_wr_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [pcmu_pkg::WORD_W-1:0]   packed_counts;
	logic [pcmu_pkg::MASK_W-1:0]   inc_mask;
	logic                          req_type;
	logic                          out_valid;
	logic                          out_ready;
	logic [pcmu_pkg::WORD_W-1:0]   packed_result;
	logic [1:0]                    status;

	counter_scoreboard   sb;
	int                  cycles = 0;
	int                  limit_settings;
	int                  gap_pct;
	int                  stall_pct;
	bit                  calm;

	packed_counter_mask_update #(
		.LANE_COUNT(LANES),
		.LANE_WIDTH(LANE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packed_counts(packed_counts),
		.inc_mask     (inc_mask),
		.req_type     (req_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_result(packed_result),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: give up if the run hangs anywhere.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles, %0d beats outstanding",
				$time, cycles, sb.pending());
			$display("packed_counter_mask_update test failed");
			$finish;
		end
	end

	// Receiver: take result beats and check them. Signals read straight after
	// the edge still hold their pre-edge values, so this is the handshake that
	// just happened. Stall in random bursts, never once calm is set.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(packed_result, status);
			if (stall_left > 0 && !calm) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(99) < stall_pct) begin
				out_ready <= 1'b0;
				stall_left = int'($urandom_range(13, 1)) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Present one input beat and hold it until the block takes it. An optional
	// gap first drops valid for a burst of cycles; valid is only ever raised
	// again on a later edge than the one that lowered it.
	task automatic send_beat(input logic [pcmu_pkg::WORD_W-1:0] counts,
			input logic [pcmu_pkg::MASK_W-1:0] mask, input logic add);
		if (!calm && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		packed_counts <= counts;
		inc_mask      <= mask;
		req_type      <= add;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(counts, mask, add);
	endtask

	// Hold off the sender until every outstanding result beat has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Change lane_limit only with the block empty; give the two pipeline
	// stages a few spare cycles first.
	task automatic write_limit(input logic [pcmu_pkg::LIMIT_W-1:0] value);
		drain();
		repeat (3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.limit    = value;
		limit_settings++;
	endtask

	// Build a word that mostly gets through: in add mode every lane sits at
	// or under the limit and masked lanes leave room for the step; in subtract
	// mode masked lanes are non-zero. Now and then disturb one lane so the
	// error paths are hit from otherwise clean words.
	function automatic logic [pcmu_pkg::WORD_W-1:0] shape_counts(input logic add,
			input logic [pcmu_pkg::MASK_W-1:0] mask,
			input logic [pcmu_pkg::LIMIT_W-1:0] limit);
		logic [63:0] word;
		logic [63:0] lm;
		logic [63:0] cap;
		logic [63:0] val;
		int          pos;
		int          i;
		lm   = (64'd1 << LANE_BITS) - 64'd1;
		cap  = ({33'd0, limit} < lm) ? {33'd0, limit} : lm;
		word = {$urandom, $urandom};
		for (i = 0; i < LANES; i++) begin
			pos = i * LANE_BITS;
			if (pos >= pcmu_pkg::WORD_W)
				break;
			if (add)
				val = (i < pcmu_pkg::MASK_W && mask[i] && cap > 0) ?
					64'($urandom_range(32'(cap - 1), 0)) :
					64'($urandom_range(32'(cap), 0));
			else
				val = (i < pcmu_pkg::MASK_W && mask[i]) ?
					64'($urandom_range(32'(lm), 1)) : 64'($urandom_range(32'(lm), 0));
			word = (word & ~(lm << pos)) | (val << pos);
		end
		if ($urandom_range(7) == 0) begin
			pos  = int'($urandom_range(LANES - 1)) * LANE_BITS;
			val  = add ? 64'($urandom_range(32'(lm), 0)) : 64'd0;
			if (pos < pcmu_pkg::WORD_W)
				word = (word & ~(lm << pos)) | (val << pos);
		end
		return word;
	endfunction

	// Random beats: three in four are shaped, the rest pure noise.
	task automatic run_random(input int n);
		logic [pcmu_pkg::MASK_W-1:0] mask;
		logic                        add;
		logic [pcmu_pkg::WORD_W-1:0] counts;
		int                          k;
		for (k = 0; k < n; k++) begin
			add = 1'($urandom_range(1));
			case ($urandom_range(9))
				0:       mask = '0;
				1:       mask = '1;
				default: mask = pcmu_pkg::MASK_W'($urandom);
			endcase
			if ($urandom_range(3) == 0)
				counts = {$urandom, $urandom};
			else
				counts = shape_counts(add, mask, sb.limit);
			send_beat(counts, mask, add);
		end
	endtask

	initial begin
		sb             = new();
		limit_settings = 0;
		gap_pct        = 20;
		stall_pct      = 20;
		calm           = 1'b0;
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= '0;
		in_valid      <= 1'b0;
		packed_counts <= '0;
		inc_mask      <= '0;
		req_type      <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats on the reset limit of 15.
		send_beat(64'h0, 16'hFFFF, 1'b1);                   // every lane to one
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b1); // full lanes, no step
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 1'b1); // carry out of a lane
		send_beat(64'h0, 16'hFFFF, 1'b0);                   // underflow everywhere
		send_beat(64'h0, 16'h0000, 1'b0);
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
		send_beat(64'h8000_0000_0000_0000, 16'h8000, 1'b1); // top lane only
		send_beat(64'hF000_0000_0000_0000, 16'h8000, 1'b1); // top lane carries out
		send_beat(64'h1234_5678_9ABC_DEF0, 16'h0001, 1'b0); // lowest lane is zero
		send_beat(64'h1234_5678_9ABC_DEF0, 16'hFFFE, 1'b0);
		send_beat(64'hEEEE_EEEE_EEEE_EEEE, 16'hFFFF, 1'b1); // all reach the limit
		run_random(200);

		// Limit of zero: any non-zero lane trips an add, subtract ignores it.
		write_limit('0);
		gap_pct   = 0;
		stall_pct = 0;
		send_beat(64'h0, 16'h0000, 1'b1);
		send_beat(64'h0, 16'h0400, 1'b1);
		send_beat(64'h0000_0000_0100_0000, 16'h0000, 1'b1); // unmasked lane too high
		send_beat(64'h0000_0000_0100_0000, 16'h0040, 1'b0);
		run_random(150);

		// Largest limit: lane capacity becomes the only bound.
		write_limit({pcmu_pkg::LIMIT_W{1'b1}});
		gap_pct   = 35;
		stall_pct = 10;
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b1);
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 1'b1);
		run_random(120);
		drain();
		run_random(130);

		// Mid-range limit.
		write_limit(31'd7);
		gap_pct   = 10;
		stall_pct = 40;
		send_beat(64'h0000_0000_0000_0800, 16'h0000, 1'b1); // unmasked lane over
		send_beat(64'h0000_0000_0000_0600, 16'h0004, 1'b1); // rises onto the limit
		send_beat(64'h0000_0000_0000_0700, 16'h0004, 1'b1); // rises past it
		run_random(200);

		write_limit(31'($urandom_range(14, 1)));
		gap_pct   = 20;
		stall_pct = 20;
		run_random(200);

		write_limit(31'd15);
		gap_pct   = 0;
		stall_pct = 30;
		run_random(200);

		write_limit(31'($urandom_range(32'h7FFF_FFFF, 16)));
		gap_pct   = 30;
		stall_pct = 0;
		run_random(200);

		// Closing stretch at full rate on both sides.
		write_limit(pcmu_pkg::LIMIT_RESET);
		calm = 1'b1;
		run_random(200);

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d beats over %0d lane_limit settings after reset:",
			sb.n_ok + sb.n_over + sb.n_under, limit_settings);
		$display("  %0d updated, %0d over limit, %0d underflow",
			sb.n_ok, sb.n_over, sb.n_under);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("packed_counter_mask_update test passed");
		else
			$display("packed_counter_mask_update test failed");
		$finish;
	end

endmodule
